// ----- hw/rtl/pvf_pkg.sv -----
package pvf_pkg;

  localparam int unsigned VidW  = 12;
  localparam int unsigned PrioW = 3;
  localparam int unsigned TciW  = 16;
  localparam int unsigned KindW = 3;
  localparam int unsigned StatW = 2;
  localparam int unsigned ActW  = 2;

  localparam logic [VidW-1:0] VidMaxValid = 12'd4094;
  localparam int unsigned     PrioShift   = 13;

  localparam logic [KindW-1:0] KIND_INGRESS = 3'd0;
  localparam logic [KindW-1:0] KIND_EGRESS  = 3'd1;
  localparam logic [KindW-1:0] KIND_ADD     = 3'd2;
  localparam logic [KindW-1:0] KIND_DEL     = 3'd3;
  localparam logic [KindW-1:0] KIND_SETPV   = 3'd4;
  localparam logic [KindW-1:0] KIND_MARK    = 3'd5;

  localparam logic [StatW-1:0] STAT_OK   = 2'd0;
  localparam logic [StatW-1:0] STAT_DROP = 2'd1;
  localparam logic [StatW-1:0] STAT_REJ  = 2'd2;

  localparam logic [ActW-1:0] ACT_NONE   = 2'd0;
  localparam logic [ActW-1:0] ACT_STRIP  = 2'd1;
  localparam logic [ActW-1:0] ACT_INSERT = 2'd2;

  // classified transaction handed from front to back
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             ok;       // update VID acceptable
    logic             chk;      // membership lookup needed
    logic             zdrop;    // VID resolved to zero
    logic             inrange;  // VID inside the membership table
    logic [VidW-1:0]  ovid;
    logic [PrioW-1:0] oprio;
    logic [ActW-1:0]  act;
    logic [TciW-1:0]  tci;
  } pvf_entry_t;

  typedef struct packed {
    logic            busy;
    logic [VidW-1:0] port_vlan;
  } pvf_back_stat_t;

endpackage

// ----- hw/rtl/pvf_ram.sv -----
module pvf_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- hw/rtl/pvf_queue.sv -----
module pvf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pvf_pkg::pvf_entry_t push_data_i,
  input  logic                pop_i,
  output pvf_pkg::pvf_entry_t head_o,
  output logic                empty_o,
  output logic                full_o
);
  import pvf_pkg::*;

  pvf_entry_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !full_o) begin
      wr_ptr_d = ~wr_ptr_q;
      cnt_d    = cnt_d + 2'd1;
    end
    if (pop_i && !empty_o) begin
      rd_ptr_d = ~rd_ptr_q;
      cnt_d    = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/pvf_front.sv -----
module pvf_front #(
  parameter int unsigned VID_COUNT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [2:0]          kind_i,
  input  logic                is_tagged_i,
  input  logic [15:0]         tci_i,
  input  logic [11:0]         prior_vid_i,
  input  logic [2:0]          prior_priority_i,
  input  logic [11:0]         vid_i,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic [11:0]         port_vlan_i,
  output logic                push_o,
  output pvf_pkg::pvf_entry_t entry_o
);
  import pvf_pkg::*;

  localparam logic [VidW:0] VidLimit = (VidW+1)'(VID_COUNT);

  logic            dvlan_mode_q;
  logic [VidW-1:0] tag_vid;
  logic            uvid_storable;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvlan_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      dvlan_mode_q <= cfg_wdata_i;
    end
  end

  assign tag_vid       = tci_i[VidW-1:0];
  assign uvid_storable = (vid_i <= VidMaxValid) && ({1'b0, vid_i} < VidLimit);
  assign push_o        = accept_i;

  always_comb begin
    entry_o      = '0;
    entry_o.kind = kind_i;
    case (kind_i)
      KIND_INGRESS: begin
        if (is_tagged_i) begin
          entry_o.ovid  = (tag_vid != '0) ? tag_vid : port_vlan_i;
          entry_o.oprio = tci_i[PrioShift +: PrioW];
          entry_o.chk   = 1'b1;
          entry_o.act   = ACT_STRIP;
        end else if (port_vlan_i != '0) begin
          entry_o.chk = 1'b1;
          if (prior_vid_i != '0) begin
            entry_o.ovid  = prior_vid_i;
            entry_o.oprio = prior_priority_i;
          end else begin
            entry_o.ovid = port_vlan_i;
          end
        end
        entry_o.zdrop   = entry_o.chk && (entry_o.ovid == '0);
        entry_o.inrange = ({1'b0, entry_o.ovid} < VidLimit);
      end
      KIND_EGRESS: begin
        entry_o.ovid  = prior_vid_i;
        entry_o.oprio = prior_priority_i;
        if (prior_vid_i == '0) begin
          entry_o.act = ACT_NONE;
        end else if ((prior_vid_i == port_vlan_i) || dvlan_mode_q) begin
          entry_o.act = is_tagged_i ? ACT_STRIP : ACT_NONE;
        end else begin
          entry_o.act = ACT_INSERT;
          entry_o.tci = {prior_priority_i, 1'b0, prior_vid_i};
        end
      end
      KIND_ADD, KIND_DEL: begin
        entry_o.ovid = vid_i;
        entry_o.ok   = (vid_i != '0) && uvid_storable;
      end
      KIND_SETPV: begin
        entry_o.ovid = vid_i;
        entry_o.ok   = uvid_storable;
      end
      KIND_MARK: begin
        entry_o.ovid = vid_i;
        entry_o.ok   = (vid_i <= VidMaxValid);
      end
      default: begin
        entry_o.ovid = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/pvf_back.sv -----
module pvf_back #(
  parameter int unsigned VID_COUNT = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  pvf_pkg::pvf_entry_t     head_i,
  output logic                    pop_o,
  output pvf_pkg::pvf_back_stat_t stat_o,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [11:0]             out_vid_o,
  output logic [2:0]              out_priority_o,
  output logic [1:0]              tag_action_o,
  output logic [15:0]             out_tci_o
);
  import pvf_pkg::*;

  localparam int unsigned AW = $clog2(VID_COUNT);
  localparam logic [AW-1:0] ClrLast = AW'(VID_COUNT - 1);
  localparam logic [AW-1:0] DefVid  = AW'(1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic            state_q, state_d;
  logic            clr_q, clr_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic [VidW-1:0] pv_q, pv_d;
  logic            done_q, done_d;
  pvf_entry_t      cur_q;

  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic            ram_wdata;
  logic            ram_rdata;
  logic            upd_write;
  logic            drop;

  logic [StatW-1:0] status_d;
  logic [VidW-1:0]  vid_d;
  logic [PrioW-1:0] prio_d;
  logic [ActW-1:0]  act_d;
  logic [TciW-1:0]  tci_d;

  assign pop_o     = !clr_q && (state_q == ST_IDLE) && !q_empty_i;
  assign upd_write = head_i.ok && ((head_i.kind == KIND_ADD) || (head_i.kind == KIND_DEL) ||
                                   (head_i.kind == KIND_SETPV));
  assign ram_we    = clr_q || (pop_o && upd_write);
  assign ram_addr  = clr_q ? cnt_q : head_i.ovid[AW-1:0];
  assign ram_wdata = clr_q ? (cnt_q == DefVid) : (head_i.kind != KIND_DEL);

  pvf_ram #(
    .WIDTH(1),
    .DEPTH(VID_COUNT)
  ) u_member_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign stat_o.busy      = clr_q || (state_q != ST_IDLE);
  assign stat_o.port_vlan = pv_q;

  always_comb begin
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    state_d = state_q;
    pv_d    = pv_q;
    done_d  = 1'b0;
    if (clr_q) begin
      cnt_d = cnt_q + AW'(1);
      if (cnt_q == ClrLast) begin
        clr_d = 1'b0;
      end
    end
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_LOOK;
          if (head_i.ok) begin
            case (head_i.kind)
              KIND_DEL, KIND_MARK: begin
                if (head_i.ovid == pv_q) begin
                  pv_d = '0;
                end
              end
              KIND_SETPV: pv_d = head_i.ovid;
              default: pv_d = pv_q;
            endcase
          end
        end
      end
      ST_LOOK: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result of the transaction in lookup
  assign drop = cur_q.zdrop || (cur_q.chk && !(cur_q.inrange && ram_rdata));

  always_comb begin
    status_d = STAT_OK;
    vid_d    = cur_q.ovid;
    prio_d   = '0;
    act_d    = ACT_NONE;
    tci_d    = '0;
    case (cur_q.kind)
      KIND_INGRESS: begin
        prio_d = cur_q.oprio;
        if (drop) begin
          status_d = STAT_DROP;
        end else begin
          act_d = cur_q.act;
        end
      end
      KIND_EGRESS: begin
        prio_d = cur_q.oprio;
        act_d  = cur_q.act;
        tci_d  = cur_q.tci;
      end
      KIND_ADD, KIND_DEL, KIND_SETPV, KIND_MARK: begin
        status_d = cur_q.ok ? STAT_OK : STAT_REJ;
      end
      default: vid_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      clr_q   <= 1'b1;
      cnt_q   <= '0;
      pv_q    <= VidW'(1);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (state_q == ST_LOOK) begin
      status_o       <= status_d;
      out_vid_o      <= vid_d;
      out_priority_o <= prio_d;
      tag_action_o   <= act_d;
      out_tci_o      <= tci_d;
    end
  end

  assign done_o = done_q;

endmodule

// ----- hw/rtl/port_vlan_ingress_egress_filter.sv -----
// 802.1Q VLAN filter for one bridge port: ingress classification with a
// membership check, egress tag strip/keep/insert, and membership/port-VLAN
// updates. Raise start_i with the item fields while busy_o is low; the
// transaction is taken on that edge. Exactly one result follows, shown for
// one cycle with done_o high, after the queue slot, the lookup register with
// the registered membership RAM read, and the output registers; results
// cannot be stalled, so sample them when done_o is high. busy_o stays high
// until the result is out; no new transaction is taken before then. After
// reset busy_o stays high while the membership RAM is cleared (VID 1 set).
// Write dvlan_mode through cfg_we_i/cfg_wdata_i only while idle.
module port_vlan_ingress_egress_filter #(
  parameter int unsigned VID_COUNT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic        is_tagged_i,
  input  logic [15:0] tci_i,
  input  logic [11:0] prior_vid_i,
  input  logic [2:0]  prior_priority_i,
  input  logic [11:0] vid_i,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [11:0] out_vid_o,
  output logic [2:0]  out_priority_o,
  output logic [1:0]  tag_action_o,
  output logic [15:0] out_tci_o
);
  import pvf_pkg::*;

  logic           accept;
  logic           push;
  pvf_entry_t     push_entry;
  pvf_entry_t     head;
  logic           q_empty;
  logic           q_full;
  logic           pop;
  pvf_back_stat_t back_stat;

  assign busy_o = back_stat.busy || !q_empty || q_full;
  assign accept = start_i && !busy_o;

  pvf_front #(
    .VID_COUNT(VID_COUNT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .kind_i          (kind_i),
    .is_tagged_i     (is_tagged_i),
    .tci_i           (tci_i),
    .prior_vid_i     (prior_vid_i),
    .prior_priority_i(prior_priority_i),
    .vid_i           (vid_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .port_vlan_i     (back_stat.port_vlan),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  pvf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_entry),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  pvf_back #(
    .VID_COUNT(VID_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .stat_o        (back_stat),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_vid_o     (out_vid_o),
    .out_priority_o(out_priority_o),
    .tag_action_o  (tag_action_o),
    .out_tci_o     (out_tci_o)
  );

endmodule

// ----- hw/rtl/pvf_checker.sv -----
module pvf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [1:0]  tag_action_o,
  input logic [15:0] out_tci_o
);
  import pvf_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted transaction");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !done_o)
    else $error("result right after accept");

  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_DROP) |-> (tag_action_o == ACT_NONE && out_tci_o == '0))
    else $error("dropped frame carries a tag action");

  a_tci_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && tag_action_o != ACT_INSERT) |-> (out_tci_o == '0))
    else $error("tci set without insert");

endmodule

bind port_vlan_ingress_egress_filter pvf_checker u_pvf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .status_o    (status_o),
  .tag_action_o(tag_action_o),
  .out_tci_o   (out_tci_o)
);
